/* src/downlink_bit_packet_framer_macros.svh */
// assertion macros for the downlink bit packet framer
// used by the top level only; no other dependencies
`ifndef DOWNLINK_BIT_PACKET_FRAMER_MACROS_SVH
`define DOWNLINK_BIT_PACKET_FRAMER_MACROS_SVH

// same-cycle implication, disabled during reset
`define DBPF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define DBPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/dbpf_pkg.sv */
// shared constants, types and helpers of the downlink bit packet framer
// no dependencies; used by dbpf_byte_build and the top level
`timescale 1ns / 1ps
`default_nettype none

package dbpf_pkg;

	localparam int unsigned DEF_MAX_FIELD_BITS = 64;
	localparam int unsigned PB_W = 13;

	localparam logic [PB_W-1:0] PACKET_BITS_RESET = 13'd560;
	localparam logic [PB_W-1:0] PACKET_BITS_MIN = 13'd16;
	localparam logic [PB_W-1:0] PACKET_BITS_MAX = 13'd4096;

	// result of forming one output byte
	typedef struct packed {
		logic [7:0] byte_val;
		logic hdr_in;
		logic [3:0] filled;
		logic [3:0] taken;
		logic [PB_W-1:0] pos_next;
	} step_t;

	// clamp the packet size and round it down to whole bytes
	function automatic logic [PB_W-1:0] eff_limit(input logic [PB_W-1:0] p);
		logic [PB_W-1:0] s;
		begin
			s = p;
			if (s < PACKET_BITS_MIN) begin
				s = PACKET_BITS_MIN;
			end
			if (s > PACKET_BITS_MAX) begin
				s = PACKET_BITS_MAX;
			end
			return {s[PB_W-1:3], 3'b000};
		end
	endfunction

endpackage

`default_nettype wire

/* src/dbpf_byte_build.sv */
// forms the next output byte from the partial byte, header and field bits
// depends on dbpf_pkg
`timescale 1ns / 1ps
`default_nettype none

module dbpf_byte_build #(
	parameter int unsigned RW = 7
) (
	input logic [7:0] part,
	input logic [2:0] part_cnt,
	input logic start_hdr,
	input logic [dbpf_pkg::PB_W-1:0] pos,
	input logic [dbpf_pkg::PB_W-1:0] limit,
	input logic [RW-1:0] rem,
	input logic [7:0] data_top,
	output dbpf_pkg::step_t step
);

	logic [3:0] n;
	logic [dbpf_pkg::PB_W-1:0] a_raw;
	logic [dbpf_pkg::PB_W-1:0] a;
	logic [3:0] a4;
	logic hdr_exists;
	logic hdr_in;
	logic [RW:0] rp;
	logic [3:0] m;
	logic [3:0] taken;
	logic [7:0] slots;
	logic [2:0] idx;

	always_comb begin
		n = 4'd8 - {1'b0, part_cnt};
		a_raw = (pos >= limit) ? '0 : (limit - pos);
		a = start_hdr ? '0 : a_raw;
		a4 = a[3:0];
		hdr_exists = start_hdr || (dbpf_pkg::PB_W'(rem) > a);
		hdr_in = hdr_exists && (a < dbpf_pkg::PB_W'(n));
		rp = hdr_in ? ((RW+1)'(rem) + (RW+1)'(1)) : (RW+1)'(rem);
		m = (rp >= (RW+1)'(n)) ? n : rp[3:0];
		taken = hdr_in ? (m - 4'd1) : m;
		// slot j holds the j-th new bit, msb first
		for (int j = 0; j < 8; j++) begin
			idx = (hdr_in && (4'(j) > a4)) ? 3'(j - 1) : 3'(j);
			if (4'(j) >= m) begin
				slots[7-j] = 1'b0;
			end else if (hdr_in && (4'(j) == a4)) begin
				slots[7-j] = start_hdr;
			end else begin
				slots[7-j] = data_top[3'd7 - idx];
			end
		end
		step.byte_val = part | (slots >> part_cnt);
		step.hdr_in = hdr_in;
		step.filled = {1'b0, part_cnt} + m;
		step.taken = taken;
		step.pos_next = hdr_in ?
			(dbpf_pkg::PB_W'(1) + dbpf_pkg::PB_W'(taken) - dbpf_pkg::PB_W'(a4)) :
			(pos + dbpf_pkg::PB_W'(taken));
	end

endmodule

`default_nettype wire

/* src/downlink_bit_packet_framer.sv */
// path: an accepted field is held in the input register; its bytes leave through the
// output byte register
// throughput: one byte per cycle unless byte_ready stalls the output; the next field
// is accepted in the cycle that the last bits of the current one are consumed
// reset: clears the control state, closes any frame, packet size returns to 560
`timescale 1ns / 1ps
`default_nettype none
`include "downlink_bit_packet_framer_macros.svh"

module downlink_bit_packet_framer #(
	parameter int unsigned MAX_FIELD_BITS = dbpf_pkg::DEF_MAX_FIELD_BITS,
	localparam int unsigned RW = $clog2(MAX_FIELD_BITS + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [dbpf_pkg::PB_W-1:0] packet_bits,
	input logic field_valid,
	output logic field_ready,
	input logic [MAX_FIELD_BITS-1:0] field_value,
	input logic [RW-1:0] field_width,
	input logic end_of_frame,
	output logic byte_valid,
	input logic byte_ready,
	output logic [7:0] frame_byte,
	output logic packet_first,
	output logic frame_last
);

	logic [dbpf_pkg::PB_W-1:0] limit_q;
	logic busy_q;
	logic frame_open_q;
	logic [7:0] part_q;
	logic [2:0] part_cnt_q;
	logic hdr_q;
	logic [dbpf_pkg::PB_W-1:0] pos_q;
	logic [MAX_FIELD_BITS-1:0] val_q;
	logic [RW-1:0] rem_q;
	logic end_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic out_first_q;
	logic out_last_q;

	dbpf_pkg::step_t step;
	logic step_en;
	logic [RW-1:0] rem_next;
	logic done;
	logic full;
	logic emit;
	logic load;
	logic [RW-1:0] w_sat;

	dbpf_byte_build #(
		.RW(RW)
	) u_build (
		.part(part_q),
		.part_cnt(part_cnt_q),
		.start_hdr(!frame_open_q),
		.pos(pos_q),
		.limit(limit_q),
		.rem(rem_q),
		.data_top(val_q[MAX_FIELD_BITS-1 -: 8]),
		.step(step)
	);

	always_comb begin
		step_en = busy_q && (!out_valid_q || byte_ready);
		rem_next = rem_q - RW'(step.taken);
		done = (rem_next == '0);
		full = (step.filled == 4'd8);
		emit = full || (done && end_q && (step.filled != 4'd0));
		field_ready = !busy_q || (step_en && done);
		load = field_valid && field_ready;
		w_sat = (field_width > RW'(MAX_FIELD_BITS)) ? RW'(MAX_FIELD_BITS) : field_width;
	end

	assign cfg_ready = 1'b1;
	assign byte_valid = out_valid_q;
	assign frame_byte = out_byte_q;
	assign packet_first = out_first_q;
	assign frame_last = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= dbpf_pkg::PACKET_BITS_RESET;
		end else if (cfg_valid) begin
			limit_q <= dbpf_pkg::eff_limit(packet_bits);
		end
	end

	// input register: field bits kept msb-aligned, consumed from the top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (step_en && done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= field_value << (RW'(MAX_FIELD_BITS) - w_sat);
			rem_q <= w_sat;
			end_q <= end_of_frame;
		end else if (step_en) begin
			val_q <= val_q << step.taken;
			rem_q <= rem_next;
		end
	end

	// packing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			part_q <= '0;
			part_cnt_q <= '0;
			hdr_q <= 1'b0;
			pos_q <= '0;
		end else if (step_en) begin
			if (done && end_q) begin
				frame_open_q <= 1'b0;
				part_q <= '0;
				part_cnt_q <= '0;
				hdr_q <= 1'b0;
				pos_q <= '0;
			end else if (full) begin
				frame_open_q <= 1'b1;
				part_q <= '0;
				part_cnt_q <= '0;
				hdr_q <= 1'b0;
				pos_q <= step.pos_next;
			end else begin
				frame_open_q <= 1'b1;
				part_q <= step.byte_val;
				part_cnt_q <= step.filled[2:0];
				hdr_q <= hdr_q | step.hdr_in;
				pos_q <= step.pos_next;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en && emit) begin
			out_valid_q <= 1'b1;
		end else if (byte_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && emit) begin
			out_byte_q <= step.byte_val;
			out_first_q <= hdr_q | step.hdr_in;
			out_last_q <= done && end_q;
		end
	end

	`DBPF_ASSERT_NOW(a_fresh_frame, clk, arst_n, busy_q && !frame_open_q,
		(pos_q == '0) && (part_cnt_q == 3'd0) && !hdr_q, "frame starts with stale state")
	`DBPF_ASSERT_NOW(a_taken_bound, clk, arst_n, step_en,
		RW'(step.taken) <= rem_q, "more field bits consumed than remain")
	`DBPF_ASSERT_NEXT(a_frame_close, clk, arst_n, step_en && done && end_q,
		!frame_open_q && (part_cnt_q == 3'd0), "frame end left open state")

endmodule

`default_nettype wire

/* verif/testbench.sv */
// self-checking testbench for downlink_bit_packet_framer: bit fields in, packed bytes out
// depends on dbpf_pkg and the framer rtl; expected bytes come from a bit-level packer below
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned SETTLE = 12;
	localparam int unsigned CALM_TAIL = 30;
	localparam int unsigned RANDOM_FIELDS = 248;
	localparam int unsigned DRAIN_CYCLES = 24;
	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef enum logic [1:0] {
		REQ_FIELD,
		REQ_SIZE,
		REQ_SYNC
	} req_kind_e;

	typedef struct {
		req_kind_e kind;
		logic [63:0] value;
		logic [6:0] width;
		logic eof;
		logic [dbpf_pkg::PB_W-1:0] bits;
	} stim_t;

	typedef struct {
		logic [7:0] data;
		logic opens_packet;
		logic ends_frame;
	} framed_byte_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [dbpf_pkg::PB_W-1:0] packet_bits = '0;
	logic field_valid = 1'b0;
	logic field_ready;
	logic [63:0] field_value = '0;
	logic [6:0] field_width = '0;
	logic end_of_frame = 1'b0;
	logic byte_valid;
	logic byte_ready = 1'b0;
	logic [7:0] frame_byte;
	logic packet_first;
	logic frame_last;

	downlink_bit_packet_framer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.packet_bits(packet_bits),
		.field_valid(field_valid),
		.field_ready(field_ready),
		.field_value(field_value),
		.field_width(field_width),
		.end_of_frame(end_of_frame),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.frame_byte(frame_byte),
		.packet_first(packet_first),
		.frame_last(frame_last)
	);

	stim_t pending[$];
	framed_byte_t bytes_due[$];

	// handoff of accepted requests from the driver to the packer, registered for the next cycle
	logic took_field = 1'b0;
	logic [63:0] took_value = '0;
	logic [6:0] took_width = '0;
	logic took_eof = 1'b0;
	logic took_size = 1'b0;
	logic [dbpf_pkg::PB_W-1:0] took_bits = '0;

	int unsigned owed = 0;
	logic calm = 1'b0;
	logic stim_done = 1'b0;
	int unsigned gap = 0;
	int unsigned quiet = 0;
	int unsigned stall = 0;
	int unsigned cycles = 0;

	int unsigned errors = 0;
	int unsigned n_fields = 0;
	int unsigned n_bytes = 0;
	int unsigned n_frames = 0;
	int unsigned n_headers = 0;
	int unsigned n_sizes = 0;

	// packer state
	logic [dbpf_pkg::PB_W-1:0] size_reg = dbpf_pkg::PACKET_BITS_RESET;
	logic [7:0] acc = '0;
	int unsigned acc_cnt = 0;
	int unsigned pkt_pos = 0;
	logic frame_open = 1'b0;
	logic hdr_in_byte = 1'b0;
	int unsigned made = 0;

	function automatic int unsigned usable_packet_bits(input logic [dbpf_pkg::PB_W-1:0] p);
		int unsigned s;
		s = p;
		if (s < 16) begin
			s = 16;
		end
		if (s > 4096) begin
			s = 4096;
		end
		return s & ~32'd7;
	endfunction

	function automatic void put_bit(input logic b);
		framed_byte_t nb;
		acc = {acc[6:0], b};
		acc_cnt++;
		if (acc_cnt == 8) begin
			nb.data = acc;
			nb.opens_packet = hdr_in_byte;
			nb.ends_frame = 1'b0;
			bytes_due.insert(bytes_due.size(), nb);
			made++;
			acc = '0;
			acc_cnt = 0;
			hdr_in_byte = 1'b0;
		end
	endfunction

	function automatic void put_header(input logic b);
		hdr_in_byte = 1'b1;
		n_headers++;
		put_bit(b);
		pkt_pos = 1;
	endfunction

	function automatic void pack_field(input logic [63:0] value, input logic [6:0] width,
		input logic eof);
		int unsigned nbits;
		int unsigned limit;
		framed_byte_t nb;
		nbits = (width > 64) ? 64 : width;
		limit = usable_packet_bits(size_reg);
		made = 0;
		if (!frame_open) begin
			frame_open = 1'b1;
			put_header(1'b1);
		end
		for (int i = nbits; i > 0; i--) begin
			if (pkt_pos >= limit) begin
				put_header(1'b0);
			end
			put_bit(value[i-1]);
			pkt_pos++;
		end
		if (eof) begin
			if (acc_cnt > 0) begin
				nb.data = acc << (8 - acc_cnt);
				nb.opens_packet = hdr_in_byte;
				nb.ends_frame = 1'b1;
				bytes_due.insert(bytes_due.size(), nb);
			end else if (made > 0) begin
				// aligned end: the last byte of this field closes the frame
				nb = bytes_due[bytes_due.size() - 1];
				nb.ends_frame = 1'b1;
				bytes_due[bytes_due.size() - 1] = nb;
			end
			acc = '0;
			acc_cnt = 0;
			pkt_pos = 0;
			frame_open = 1'b0;
			hdr_in_byte = 1'b0;
			n_frames++;
		end
	endfunction

	function automatic void add_field(input logic [63:0] value, input logic [6:0] width,
		input logic eof);
		stim_t s;
		s.kind = REQ_FIELD;
		s.value = value;
		s.width = width;
		s.eof = eof;
		s.bits = '0;
		pending.insert(pending.size(), s);
	endfunction

	function automatic void add_size(input logic [dbpf_pkg::PB_W-1:0] bits);
		stim_t s;
		s.kind = REQ_SIZE;
		s.value = '0;
		s.width = '0;
		s.eof = 1'b0;
		s.bits = bits;
		pending.insert(pending.size(), s);
	endfunction

	function automatic void add_sync();
		stim_t s;
		s.kind = REQ_SYNC;
		s.value = '0;
		s.width = '0;
		s.eof = 1'b0;
		s.bits = '0;
		pending.insert(pending.size(), s);
	endfunction

	function automatic logic [63:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r == 0) begin
			return '1;
		end
		if (r == 1) begin
			return '0;
		end
		return {$urandom, $urandom};
	endfunction

	function automatic logic [6:0] pick_width();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			return 7'd0;
		end
		if (r == 1) begin
			return 7'($urandom_range(65, 127));
		end
		if (r < 5) begin
			return 7'd64;
		end
		return 7'($urandom_range(1, 64));
	endfunction

	function automatic logic [dbpf_pkg::PB_W-1:0] pick_size();
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 13'd16;
			1: return 13'd24;
			2: return 13'd4096;
			3: return 13'($urandom_range(0, 8191));
			4, 5: return 13'd560;
			default: return 13'($urandom_range(2, 40) * 8);
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// driver: one request at a time from the pending queue
	always @(posedge clk) begin : drive_requests
		logic fire_field;
		logic fire_size;
		logic next_fv;
		logic next_cv;
		stim_t head;
		fire_field = field_valid && field_ready;
		fire_size = cfg_valid && cfg_ready;
		next_fv = field_valid && !fire_field;
		next_cv = cfg_valid && !fire_size;
		if (arst_n) begin
			took_field <= fire_field;
			took_value <= field_value;
			took_width <= field_width;
			took_eof <= end_of_frame;
			took_size <= fire_size;
			took_bits <= packet_bits;
			if (fire_field && !calm && $urandom_range(0, 2) == 0) begin
				gap = $urandom_range(1, 7);
			end
			if (fire_field || took_field || owed != 0) begin
				quiet = 0;
			end else if (quiet < SETTLE) begin
				quiet++;
			end
			if (!next_fv && !next_cv) begin
				if (gap > 0) begin
					gap--;
				end else if (pending.size() > 0) begin
					head = pending[0];
					case (head.kind)
						REQ_FIELD: begin
							void'(pending.pop_front());
							field_value <= head.value;
							field_width <= head.width;
							end_of_frame <= head.eof;
							next_fv = 1'b1;
						end
						REQ_SIZE: begin
							// size changes only once the framer has gone quiet
							if (quiet >= SETTLE) begin
								void'(pending.pop_front());
								packet_bits <= head.bits;
								next_cv = 1'b1;
							end
						end
						REQ_SYNC: begin
							if (owed == 0 && !took_field && !fire_field) begin
								void'(pending.pop_front());
							end
						end
						default: begin
							void'(pending.pop_front());
						end
					endcase
				end else begin
					stim_done <= 1'b1;
				end
			end
			calm <= pending.size() < CALM_TAIL;
		end
		field_valid <= next_fv;
		cfg_valid <= next_cv;
	end

	// monitor: packs each accepted request, then checks the byte stream
	always @(posedge clk) begin : check_bytes
		framed_byte_t want;
		if (arst_n) begin
			if (took_size) begin
				size_reg = took_bits;
				n_sizes++;
			end
			if (took_field) begin
				pack_field(took_value, took_width, took_eof);
				n_fields++;
			end
			if (byte_valid && byte_ready) begin
				if (bytes_due.size() == 0) begin
					$error("unexpected byte %02h (packet_first %0b, frame_last %0b)",
						frame_byte, packet_first, frame_last);
					errors++;
				end else begin
					want = bytes_due.pop_front();
					n_bytes++;
					if (frame_byte !== want.data) begin
						$error("frame_byte: expected %02h, got %02h", want.data, frame_byte);
						errors++;
					end
					if (packet_first !== want.opens_packet) begin
						$error("packet_first: expected %0b, got %0b", want.opens_packet,
							packet_first);
						errors++;
					end
					if (frame_last !== want.ends_frame) begin
						$error("frame_last: expected %0b, got %0b", want.ends_frame,
							frame_last);
						errors++;
					end
				end
			end
			owed <= bytes_due.size();
			if (stall > 0) begin
				stall--;
				byte_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				stall = $urandom_range(1, 7) - 1;
				byte_ready <= 1'b0;
			end else begin
				byte_ready <= 1'b1;
			end
		end
	end

	initial begin : run_test
		int unsigned nrand;
		int unsigned nf;
		int unsigned r;

		// directed: frame start, field extremes, zero and oversized widths
		add_field(64'h1, 7'd1, 1'b0);
		add_field('1, 7'd64, 1'b0);
		add_field('0, 7'd64, 1'b0);
		add_field({$urandom, $urandom}, 7'd0, 1'b0);
		add_field({$urandom, $urandom}, 7'd127, 1'b0);
		add_field({$urandom, $urandom}, 7'd65, 1'b0);
		add_field({$urandom, $urandom}, 7'd3, 1'b1);
		// header plus seven bits ends exactly on a byte
		add_field(64'h55, 7'd7, 1'b1);
		// aligned, then a zero-width end: frame closes with no marked byte
		add_field(64'h2a, 7'd7, 1'b0);
		add_field({$urandom, $urandom}, 7'd0, 1'b1);
		// a frame of nothing but its header
		add_field({$urandom, $urandom}, 7'd0, 1'b1);
		// smallest packets, headers every two bytes
		add_size(13'd16);
		add_field({$urandom, $urandom}, 7'd64, 1'b0);
		add_field({$urandom, $urandom}, 7'd64, 1'b0);
		add_field({$urandom, $urandom}, 7'd64, 1'b1);
		add_size(13'd0);
		add_field({$urandom, $urandom}, 7'd64, 1'b1);
		// oversized register value, then shrink the packet inside an open frame
		add_size(13'd8191);
		add_field({$urandom, $urandom}, 7'd64, 1'b0);
		add_field({$urandom, $urandom}, 7'd64, 1'b0);
		add_size(13'd16);
		add_field({$urandom, $urandom}, 7'd8, 1'b0);
		add_field({$urandom, $urandom}, 7'd20, 1'b1);
		add_size(13'd4096);
		add_field({$urandom, $urandom}, 7'd64, 1'b1);
		// not a multiple of eight
		add_size(13'd21);
		add_field({$urandom, $urandom}, 7'd64, 1'b0);
		add_field({$urandom, $urandom}, 7'd64, 1'b1);
		add_sync();

		// random frames under changing packet sizes
		nrand = 0;
		while (nrand < RANDOM_FIELDS) begin
			if ($urandom_range(0, 2) == 0) begin
				add_size(pick_size());
			end
			r = $urandom_range(0, 7);
			nf = (r == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
			for (int f = 0; f < nf; f++) begin
				add_field(pick_value(), pick_width(), f == nf - 1);
				nrand++;
				if (f != nf - 1 && $urandom_range(0, 14) == 0) begin
					add_size(pick_size());
				end
			end
			if ($urandom_range(0, 9) == 0) begin
				add_sync();
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		do begin
			@(negedge clk);
		end while (!(stim_done && owed == 0 && !took_field && !took_size));
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (bytes_due.size() != 0) begin
			$error("%0d expected bytes never arrived", bytes_due.size());
			errors++;
		end

		$display("covered %0d fields in %0d frames, %0d bytes checked, %0d packet headers",
			n_fields, n_frames, n_bytes, n_headers);
		$display("packet size written %0d times, %0d mismatches", n_sizes, errors);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
